[hdl/phase_unwrap_error_map_core_assert.svh]
// Assertion macros for the phase unwrap error map core.
// Each macro takes a label, the clock, the active-low reset, an antecedent
// and a consequent.
`ifndef PHASE_UNWRAP_ERROR_MAP_CORE_ASSERT_SVH
`define PHASE_UNWRAP_ERROR_MAP_CORE_ASSERT_SVH

// Same-cycle implication.
`define PUEM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("phase unwrap error map: port rule broken");

// Next-cycle implication.
`define PUEM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("phase unwrap error map: port rule broken");

`endif

[hdl/puem_pkg.sv]
`default_nettype none

package puem_pkg;

    localparam int COORD_W     = 11;
    localparam int COUNT_W     = 23;
    localparam int MARK_W      = 8;
    localparam int DIM_W       = 12;
    localparam int THR_W       = 31;
    localparam int CFG_DATA_W  = 31;
    localparam int CFG_INDEX_W = 2;
    localparam int OUT_TDATA_W = 56;

    localparam logic [MARK_W-1:0]  MARK_NONE    = 8'd0;
    localparam logic [MARK_W-1:0]  MARK_OUTSIDE = 8'd100;
    localparam logic [MARK_W-1:0]  MARK_ERROR   = 8'd255;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
    localparam logic [DIM_W-1:0]   ROWS_MAX     = 12'd2048;

    // result queue, one entry per input item that yields results
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_WIDTH    = 2'd0,
        CFG_FRAME_HEIGHT   = 2'd1,
        CFG_JUMP_THRESHOLD = 2'd2
    } t_cfg_index;

    // position and frame flags of one accepted pixel
    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last_col;
        logic               last_row;
        logic               has_first;
        logic               x_zero;
    } t_pos_info;

    // everything needed to form the one or two results of a pixel
    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [MARK_W-1:0]  mark;
        logic [COUNT_W-1:0] count;
        logic               has_first;
        logic               last_row;
        logic               last_col;
    } t_item;

endpackage

`default_nettype wire

[hdl/puem_line_mem.sv]
`default_nettype none

module puem_line_mem #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11,
    parameter int DW    = 33
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [DW-1:0] i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[hdl/puem_classify.sv]
`default_nettype none

module puem_classify import puem_pkg::*; #(
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire t_pos_info                     i_info,
    input  wire logic signed [SAMPLE_BITS-1:0] i_cur,
    input  wire logic signed [SAMPLE_BITS-1:0] i_col0_sample,
    input  wire logic                          i_col0_mask,
    input  wire logic        [SAMPLE_BITS:0]   i_rd_data,
    input  wire logic        [THR_W-1:0]       i_threshold,
    output logic                               o_push,
    output t_item                              o_item,
    output logic             [1:0]             o_pending
);

    localparam int DW = (SAMPLE_BITS + 1 > THR_W + 1) ? SAMPLE_BITS + 1 : THR_W + 1;

    // stage 1: line data arrives
    logic                          r_s1_valid;
    t_pos_info                     r_s1_info;
    logic signed [SAMPLE_BITS-1:0] r_s1_cur;
    logic signed [SAMPLE_BITS-1:0] r_s1_col0_sample;
    logic                          r_s1_col0_mask;
    logic signed [SAMPLE_BITS-1:0] r_prev_sample;
    logic                          r_prev_mask;

    // stage 2: differences ready
    logic                          r_s2_valid;
    t_pos_info                     r_s2_info;
    logic signed [DW-1:0]          r_s2_dr;
    logic signed [DW-1:0]          r_s2_db;
    logic                          r_s2_mask;
    logic signed [DW-1:0]          r_thr_pos;
    logic signed [DW-1:0]          r_thr_neg;
    logic        [COUNT_W-1:0]     r_err;

    logic signed [SAMPLE_BITS-1:0] above;
    logic signed [SAMPLE_BITS-1:0] right;
    logic                          above_mask;
    logic signed [DW-1:0]          above_x;
    logic signed [DW-1:0]          right_x;
    logic signed [DW-1:0]          cur_x;
    logic signed [DW-1:0]          thr_x;
    logic                          jump;
    logic                          is_err;
    logic        [COUNT_W-1:0]     n_err;
    logic                          s1_push;

    // the pixel above is the previous item's right neighbour, except in column 0
    assign right      = signed'(i_rd_data[SAMPLE_BITS-1:0]);
    assign above      = r_s1_info.x_zero ? r_s1_col0_sample : r_prev_sample;
    assign above_mask = r_s1_info.x_zero ? r_s1_col0_mask : r_prev_mask;
    assign above_x    = DW'(above);
    assign right_x    = DW'(right);
    assign cur_x      = DW'(r_s1_cur);
    assign thr_x      = signed'(DW'(i_threshold));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_err      <= '0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            if (r_s2_valid) begin
                r_err <= (r_s2_info.last_row && r_s2_info.last_col) ? '0 : n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_thr_pos <= thr_x;
        r_thr_neg <= -thr_x;
        if (i_valid) begin
            r_s1_info        <= i_info;
            r_s1_cur         <= i_cur;
            r_s1_col0_sample <= i_col0_sample;
            r_s1_col0_mask   <= i_col0_mask;
        end
        if (r_s1_valid) begin
            r_prev_sample <= right;
            r_prev_mask   <= i_rd_data[SAMPLE_BITS];
            r_s2_info     <= r_s1_info;
            r_s2_dr       <= above_x - right_x;
            r_s2_db       <= above_x - cur_x;
            r_s2_mask     <= above_mask;
        end
    end

    // |d| > t  is  d > t or d < -t
    assign jump = (r_s2_dr > r_thr_pos) || (r_s2_dr < r_thr_neg) ||
                  (r_s2_db > r_thr_pos) || (r_s2_db < r_thr_neg);
    assign is_err = r_s2_info.has_first && !r_s2_info.last_col && r_s2_mask && jump;
    assign n_err  = (is_err && (r_err != COUNT_MAX)) ? r_err + COUNT_W'(1) : r_err;

    always_comb begin
        o_item.row       = r_s2_info.row;
        o_item.col       = r_s2_info.col;
        o_item.count     = n_err;
        o_item.has_first = r_s2_info.has_first;
        o_item.last_row  = r_s2_info.last_row;
        o_item.last_col  = r_s2_info.last_col;
        if (r_s2_info.last_col) begin
            o_item.mark = MARK_NONE;
        end else if (!r_s2_mask) begin
            o_item.mark = MARK_OUTSIDE;
        end else if (jump) begin
            o_item.mark = MARK_ERROR;
        end else begin
            o_item.mark = MARK_NONE;
        end
    end

    assign o_push    = r_s2_valid && (r_s2_info.has_first || r_s2_info.last_row);
    assign s1_push   = r_s1_valid && (r_s1_info.has_first || r_s1_info.last_row);
    assign o_pending = {1'b0, s1_push} + {1'b0, o_push};

endmodule

`default_nettype wire

[hdl/puem_out_queue.sv]
`default_nettype none

module puem_out_queue import puem_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    input  wire t_item                  i_item,
    output logic      [QUEUE_CW-1:0]    o_count,
    output logic                        o_tvalid,
    input  wire logic                   i_tready,
    output logic      [OUT_TDATA_W-1:0] o_tdata,
    output logic                        o_tlast,
    output logic      [0:0]             o_tuser
);

    t_item               r_q [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;
    logic                r_second;

    t_item               head;
    logic                show_first;
    logic                take;
    logic                pop;
    logic [COORD_W-1:0]  out_row;
    logic [MARK_W-1:0]   out_mark;

    assign head       = r_q[r_rd_ptr];
    assign show_first = head.has_first && !r_second;
    assign take       = o_tvalid && i_tready;
    assign pop        = take && !(show_first && head.last_row);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_second <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
                r_second <= 1'b0;
            end else if (take) begin
                r_second <= 1'b1;
            end
            r_count <= r_count + QUEUE_CW'(i_push) - QUEUE_CW'(pop);
        end
    end

    // first beat classifies the row above; second is the last-row pixel itself
    assign out_row  = show_first ? head.row - COORD_W'(1) : head.row;
    assign out_mark = show_first ? head.mark : MARK_NONE;

    assign o_count    = r_count;
    assign o_tvalid   = (r_count != '0);
    assign o_tdata    = {3'b000, head.count, out_mark, head.col, out_row};
    assign o_tlast    = show_first ? !head.last_row : 1'b1;
    assign o_tuser[0] = show_first ? 1'b0 : head.last_col;

endmodule

`default_nettype wire

[hdl/phase_unwrap_error_map_core.sv]
// Channel   Dir  Beat contents (lowest bit first)                 Handshake
// s_axis    in   tdata: phase_sample; tuser: inside_mask          tvalid/tready
// m_axis    out  tdata: row, col, mark, count; tlast: run_end;    tvalid/tready
//                tuser: frame_done
// cfg       in   index 0 width, 1 height, 2 threshold; data       i_cfg_valid/o_cfg_ready
//
// One pixel per cycle while neither stream stalls; a last-row pixel yields two
// beats, so there the single output port sets the pace.
// Each input beat passes line read, difference, then compare and count before
// its first output beat can leave the result queue.
// Reset clears position, count and queue; line memory contents are undefined
// until written, so there is no clearing pass.
// A stalled output fills a four-entry result queue; input tready drops once the
// queue plus the items in flight would fill it.
`default_nettype none

module phase_unwrap_error_map_core import puem_pkg::*; #(
    parameter int MAX_WIDTH   = 2048,
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // configuration writes
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]      i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]       i_cfg_data,
    // pixel stream in
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata, // phase_sample
    input  wire logic [0:0]                  s_axis_tuser,  // inside_mask
    // result stream out
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // result_row[10:0], result_col[21:11], mark_code[29:22], error_count[52:30]
    output logic      [OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                             m_axis_tlast,  // run_end
    output logic      [0:0]                  m_axis_tuser   // frame_done
);

    localparam int             AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int             POS_W = 14;
    localparam logic [POS_W-1:0] MAX_W = POS_W'(MAX_WIDTH);

    // configuration registers
    logic [DIM_W-1:0]   r_frame_width;
    logic [DIM_W-1:0]   r_frame_height;
    logic [THR_W-1:0]   r_threshold;

    // raster position and column-0 sample of the previous row
    logic [COORD_W-1:0]            r_col_pos;
    logic [COORD_W-1:0]            r_row_pos;
    logic signed [SAMPLE_BITS-1:0] r_col0_sample;
    logic                          r_col0_mask;

    logic                          accept;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [POS_W-1:0]              w_eff;
    logic [POS_W-1:0]              x_pos;
    logic [POS_W-1:0]              x_next;
    logic [DIM_W-1:0]              h_eff;
    logic [DIM_W-1:0]              r_next;
    logic                          last_col;
    logic                          last_row;
    t_pos_info                     info;
    logic [SAMPLE_BITS:0]          rd_data;
    logic                          push;
    t_item                         item;
    logic [1:0]                    pending;
    logic [QUEUE_CW-1:0]           q_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 12'd2048;
            r_frame_height <= 12'd2048;
            r_threshold    <= 31'd32768;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_FRAME_WIDTH:    r_frame_width  <= i_cfg_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT:   r_frame_height <= i_cfg_data[DIM_W-1:0];
                CFG_JUMP_THRESHOLD: r_threshold    <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // take a pixel only when the queue can hold its results and those in flight
    assign s_axis_tready = (4'(q_count) + 4'(pending)) < 4'(QUEUE_DEPTH);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign sample        = signed'(s_axis_tdata[SAMPLE_BITS-1:0]);

    // clamp sizes and position into range
    always_comb begin
        w_eff = {2'b00, r_frame_width};
        if (w_eff < POS_W'(2)) begin
            w_eff = POS_W'(2);
        end else if (w_eff > MAX_W) begin
            w_eff = MAX_W;
        end
        h_eff = r_frame_height;
        if (h_eff < DIM_W'(2)) begin
            h_eff = DIM_W'(2);
        end else if (h_eff > ROWS_MAX) begin
            h_eff = ROWS_MAX;
        end
        x_pos = {3'b000, r_col_pos};
        if (x_pos >= MAX_W) begin
            x_pos = MAX_W - POS_W'(1);
        end
    end

    assign x_next   = x_pos + POS_W'(1);
    assign r_next   = {1'b0, r_row_pos} + DIM_W'(1);
    assign last_col = (x_next >= w_eff);
    assign last_row = (r_next >= h_eff);

    always_comb begin
        info.row       = r_row_pos;
        info.col       = x_pos[COORD_W-1:0];
        info.last_col  = last_col;
        info.last_row  = last_row;
        info.has_first = (r_row_pos != '0);
        info.x_zero    = (x_pos == '0);
    end

    // advance the raster position; wrap at row and frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_pos <= '0;
            r_row_pos <= '0;
        end else if (accept) begin
            if (last_col) begin
                r_col_pos <= '0;
                r_row_pos <= last_row ? '0 : r_next[COORD_W-1:0];
            end else begin
                r_col_pos <= x_next[COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && info.x_zero) begin
            r_col0_sample <= sample;
            r_col0_mask   <= s_axis_tuser[0];
        end
    end

    // line memory: write this column, read the right neighbour from the row above
    puem_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW),
        .DW    (SAMPLE_BITS + 1)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_wr_en   (accept),
        .i_wr_addr (x_pos[AW-1:0]),
        .i_wr_data ({s_axis_tuser[0], sample}),
        .i_rd_en   (accept),
        .i_rd_addr (x_next[AW-1:0]),
        .o_rd_data (rd_data)
    );

    puem_classify #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_classify (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (accept),
        .i_info        (info),
        .i_cur         (sample),
        .i_col0_sample (r_col0_sample),
        .i_col0_mask   (r_col0_mask),
        .i_rd_data     (rd_data),
        .i_threshold   (r_threshold),
        .o_push        (push),
        .o_item        (item),
        .o_pending     (pending)
    );

    puem_out_queue u_out_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (item),
        .o_count  (q_count),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast),
        .o_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

[hdl/puem_port_checker.sv]
`default_nettype none
`include "phase_unwrap_error_map_core_assert.svh"

module puem_port_checker import puem_pkg::*; (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_tvalid,
    input wire logic                   i_tready,
    input wire logic [OUT_TDATA_W-1:0] i_tdata,
    input wire logic                   i_tlast,
    input wire logic [0:0]             i_tuser
);

    logic [MARK_W-1:0] mark;

    assign mark = i_tdata[29:22];

    // the frame's final beat ends its run and carries no mark
    `PUEM_ASSERT_IMP(a_done_ends_run, i_clk, i_rst_n, i_tvalid && i_tuser[0], i_tlast)
    `PUEM_ASSERT_IMP(a_done_mark_none, i_clk, i_rst_n, i_tvalid && i_tuser[0], mark == MARK_NONE)
    `PUEM_ASSERT_IMP(a_mark_known, i_clk, i_rst_n, i_tvalid, mark == MARK_NONE || mark == MARK_OUTSIDE || mark == MARK_ERROR)
    // a stalled beat holds
    `PUEM_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_tvalid && !i_tready, i_tvalid && $stable(i_tdata))

endmodule

bind phase_unwrap_error_map_core puem_port_checker u_port_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_tvalid (m_axis_tvalid),
    .i_tready (m_axis_tready),
    .i_tdata  (m_axis_tdata),
    .i_tlast  (m_axis_tlast),
    .i_tuser  (m_axis_tuser)
);

`default_nettype wire

[tb/tb_top.sv]
module tb_top;
    import puem_pkg::*;

    localparam int LINE_MAX      = 2048;  // line store depth, the core's default MAX_WIDTH
    localparam int PHASE_W       = 32;
    localparam int TOTAL_PIXELS  = 680;   // directed opening plus about 650 random beats
    localparam int CALM_PIXELS   = 100;   // closing stretch with no idling on either side
    localparam int SETTLE_CYCLES = 8;     // comfortably past the pipeline depth
    localparam int STALL_LIMIT   = 1000;  // cycles with no beat on any channel
    localparam int REPORT_MAX    = 50;

    // One classified pixel as it leaves on m_axis.
    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [MARK_W-1:0]  mark;
        logic [COUNT_W-1:0] count;
        logic               run_end;
        logic               frame_done;
    } t_mark_beat;

    typedef struct {
        t_cfg_index            idx;
        logic [CFG_DATA_W-1:0] val;
    } t_reg_write;

    // Mirrors the line store, raster position and error count of the core, and
    // holds the marks still owed on the output.
    class error_map_scoreboard;
        logic signed [PHASE_W-1:0] line_phase [LINE_MAX];
        logic                      line_inside [LINE_MAX];
        int unsigned               col_pos;
        int unsigned               row_pos;
        int unsigned               filled;      // line entries written since reset
        logic [COUNT_W-1:0]        err_total;
        logic [DIM_W-1:0]          width_reg;
        logic [DIM_W-1:0]          height_reg;
        logic [THR_W-1:0]          thresh_reg;
        t_mark_beat                marks_due [$];
        int                        fails;

        function new();
            col_pos    = 0;
            row_pos    = 0;
            filled     = 0;
            err_total  = '0;
            width_reg  = 12'd2048;
            height_reg = 12'd2048;
            thresh_reg = 31'd32768;
            fails      = 0;
        endfunction

        function int unsigned pending();
            return marks_due.size();
        endfunction

        function void set_reg(t_cfg_index idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_FRAME_WIDTH:    width_reg  = val[DIM_W-1:0];
                CFG_FRAME_HEIGHT:   height_reg = val[DIM_W-1:0];
                CFG_JUMP_THRESHOLD: thresh_reg = val[THR_W-1:0];
                default: ;
            endcase
        endfunction

        // Classify the pixel above the accepted one and, on the last row, the
        // accepted pixel itself; then advance the raster position.
        function void note_pixel(logic [PHASE_W-1:0] phase, logic in_mask);
            int unsigned       w;
            int unsigned       h;
            int unsigned       x;
            int unsigned       r;
            bit                last_col;
            bit                last_row;
            logic [MARK_W-1:0] mark;
            longint            up;
            longint            d_right;
            longint            d_down;
            longint            limit;
            w = (width_reg < 2) ? 2 : (width_reg > LINE_MAX) ? LINE_MAX : width_reg;
            h = (height_reg < 2) ? 2 : (height_reg > ROWS_MAX) ? ROWS_MAX : height_reg;
            x = col_pos;
            r = row_pos;
            // a position already past a shrunken size ends the row or the frame
            last_col = (x + 1 >= w);
            last_row = (r + 1 >= h);
            if (r != 0) begin
                mark = MARK_NONE;
                if (!last_col) begin
                    if (!line_inside[x]) begin
                        mark = MARK_OUTSIDE;
                    end else begin
                        up      = longint'(line_phase[x]);
                        d_right = up - longint'(line_phase[x + 1]);
                        d_down  = up - longint'(signed'(phase));
                        if (d_right < 0) d_right = -d_right;
                        if (d_down < 0) d_down = -d_down;
                        limit = longint'(thresh_reg);
                        if (d_right > limit || d_down > limit) begin
                            mark = MARK_ERROR;
                            if (err_total != COUNT_MAX) err_total = err_total + 1'b1;
                        end
                    end
                end
                marks_due.push_back('{COORD_W'(r - 1), COORD_W'(x), mark, err_total,
                                      !last_row, 1'b0});
            end
            if (last_row)
                marks_due.push_back('{COORD_W'(r), COORD_W'(x), MARK_NONE, err_total,
                                      1'b1, last_col});
            line_phase[x]  = signed'(phase);
            line_inside[x] = in_mask;
            if (x + 1 > filled) filled = x + 1;
            if (last_col) begin
                col_pos = 0;
                if (last_row) begin
                    row_pos   = 0;
                    err_total = '0;
                end else begin
                    row_pos = r + 1;
                end
            end else begin
                col_pos = x + 1;
            end
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                if (fails < REPORT_MAX)
                    $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
                fails++;
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data, logic last, logic done);
            t_mark_beat want;
            t_mark_beat got;
            // tdata from the lowest bit: row, col, mark, count
            got = '{data[10:0], data[21:11], data[29:22], data[52:30], last, done};
            if (marks_due.size() == 0) begin
                if (fails < REPORT_MAX)
                    $display("%0t: result beat expected none, got row %0d col %0d mark %0d",
                             $time, got.row, got.col, got.mark);
                fails++;
                return;
            end
            want = marks_due.pop_front();
            check_field("result_row", want.row, got.row);
            check_field("result_col", want.col, got.col);
            check_field("mark_code", want.mark, got.mark);
            check_field("error_count", want.count, got.count);
            check_field("run_end", want.run_end, got.run_end);
            check_field("frame_done", want.frame_done, got.frame_done);
        endfunction
    endclass

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_cfg_valid   = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_INDEX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data    = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [PHASE_W-1:0]      s_axis_tdata  = '0;   // phase_sample
    logic [0:0]              s_axis_tuser  = '0;   // inside_mask
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;         // row, col, mark, count
    logic                    m_axis_tlast;         // run_end
    logic [0:0]              m_axis_tuser;         // frame_done

    error_map_scoreboard sb = new();
    t_reg_write          reg_writes [$];
    int unsigned         pixels_sent    = 0;
    int unsigned         gap_pct        = 0;
    int unsigned         sink_stall_pct = 0;
    bit                  calm           = 1'b0;
    int unsigned         stall_left     = 0;
    int unsigned         quiet_cycles   = 0;

    phase_unwrap_error_map_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Result side: check each accepted beat, then choose tready for the next
    // cycle. Stalls come in bursts.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(1, 100) <= sink_stall_pct) begin
            stall_left    <= $urandom_range(0, 6);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: end the run once no channel has moved a beat for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
            $display("phase_unwrap_error_map_core verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one pixel beat, after an optional idle burst, and hold it until taken.
    task automatic send_pixel(input logic [PHASE_W-1:0] phase, input logic in_mask);
        if (!calm && $urandom_range(1, 100) <= gap_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= phase;
        s_axis_tuser  <= in_mask;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_pixel(phase, in_mask);
        pixels_sent++;
    endtask

    // Drop the pixel stream and let every owed mark drain. Row-0 pixels owe
    // nothing, so also let the pipeline go quiet before returning.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic void queue_reg(t_cfg_index idx, logic [CFG_DATA_W-1:0] val);
        reg_writes.push_back('{idx, val});
    endfunction

    // Issue the queued register writes back to back, then drop the channel.
    task automatic apply_regs();
        while (reg_writes.size() != 0) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= reg_writes[0].idx;
            i_cfg_data  <= reg_writes[0].val;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            sb.set_reg(reg_writes[0].idx, reg_writes[0].val);
            void'(reg_writes.pop_front());
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] cfg_val;
        logic [PHASE_W-1:0]    phase;
        logic [PHASE_W-1:0]    base;
        int unsigned           spread;
        int unsigned           mask_pct;
        int unsigned           cap;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Opposite phase extremes against the largest threshold: the full-scale
        // difference still counts as a jump. One pixel outside the mask.
        gap_pct        = 30;
        sink_stall_pct = 30;
        queue_reg(CFG_FRAME_WIDTH, 31'd3);
        queue_reg(CFG_FRAME_HEIGHT, 31'd3);
        queue_reg(CFG_JUMP_THRESHOLD, 31'h7FFF_FFFF);
        apply_regs();
        send_pixel(32'h7FFF_FFFF, 1'b1);
        send_pixel(32'h8000_0000, 1'b1);
        send_pixel(32'h0000_0000, 1'b1);
        send_pixel(32'h8000_0000, 1'b1);
        send_pixel(32'h7FFF_FFFF, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b1);
        send_pixel(32'h0000_0001, 1'b1);
        send_pixel(32'h7FFF_FFFF, 1'b1);
        send_pixel(32'h8000_0000, 1'b1);

        // Sizes below range clamp to two; a difference equal to a zero threshold
        // is no jump.
        wait_idle();
        queue_reg(CFG_FRAME_WIDTH, 31'd0);
        queue_reg(CFG_FRAME_HEIGHT, 31'd1);
        queue_reg(CFG_JUMP_THRESHOLD, 31'd0);
        apply_regs();
        send_pixel(32'h1234_5678, 1'b1);
        send_pixel(32'h1234_5678, 1'b0);
        send_pixel(32'h1234_5678, 1'b1);
        send_pixel(32'hEDCB_A987, 1'b0);

        // Threshold five: a step of exactly five passes, six is a jump.
        wait_idle();
        queue_reg(CFG_FRAME_WIDTH, 31'd1);
        queue_reg(CFG_FRAME_HEIGHT, 31'd0);
        queue_reg(CFG_JUMP_THRESHOLD, 31'd5);
        apply_regs();
        send_pixel(32'd10, 1'b1);
        send_pixel(32'd15, 1'b1);
        send_pixel(32'd16, 1'b1);
        send_pixel(32'd0, 1'b0);

        // Sizes above range clamp to the maximum; shrink the width part way along
        // row 0 so the row ends early, then shrink the height so row 2 is the last.
        wait_idle();
        queue_reg(CFG_FRAME_WIDTH, 31'h7FFF_FFFF);
        queue_reg(CFG_FRAME_HEIGHT, 31'h7FFF_FFFF);
        queue_reg(CFG_JUMP_THRESHOLD, 31'd32768);
        apply_regs();
        repeat (5) send_pixel(32'($urandom_range(0, 65536)), 1'b1);
        wait_idle();
        queue_reg(CFG_FRAME_WIDTH, 31'd3);
        apply_regs();
        send_pixel(32'd1000, 1'b1);
        send_pixel(32'd40000, 1'b1);
        send_pixel(32'd20000, 1'b1);
        send_pixel(32'd2000, 1'b0);
        wait_idle();
        queue_reg(CFG_FRAME_HEIGHT, 31'd2);
        apply_regs();
        send_pixel(32'd5000, 1'b1);
        send_pixel(32'd90000, 1'b1);
        send_pixel(32'd7, 1'b1);

        // Random frames: mostly smooth phase maps with some jumps and holes, new
        // sizes and threshold between frames, now and then a resize mid-frame.
        while (pixels_sent < TOTAL_PIXELS) begin
            wait_idle();
            calm = (pixels_sent >= TOTAL_PIXELS - CALM_PIXELS);
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 9))
                    0:       cfg_val = CFG_DATA_W'($urandom_range(0, 1));
                    1:       cfg_val = CFG_DATA_W'($urandom_range(13, 40));
                    default: cfg_val = CFG_DATA_W'($urandom_range(2, 12));
                endcase
                if ($urandom_range(0, 3) == 0)
                    cfg_val[CFG_DATA_W-1:DIM_W] = (CFG_DATA_W - DIM_W)'($urandom);
                queue_reg(CFG_FRAME_WIDTH, cfg_val);
            end
            if ($urandom_range(0, 3) != 0) begin
                cfg_val = CFG_DATA_W'($urandom_range(0, 7));
                if ($urandom_range(0, 3) == 0)
                    cfg_val[CFG_DATA_W-1:DIM_W] = (CFG_DATA_W - DIM_W)'($urandom);
                queue_reg(CFG_FRAME_HEIGHT, cfg_val);
            end
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 5))
                    0:       cfg_val = '0;
                    1:       cfg_val = '1;
                    2:       cfg_val = CFG_DATA_W'(32768);
                    3, 4:    cfg_val = CFG_DATA_W'($urandom_range(1, 4000));
                    default: cfg_val = CFG_DATA_W'($urandom);
                endcase
                queue_reg(CFG_JUMP_THRESHOLD, cfg_val);
            end
            apply_regs();

            gap_pct        = (calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 50);
            sink_stall_pct = (calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 50);
            mask_pct       = ($urandom_range(0, 1) == 1) ? $urandom_range(85, 100)
                                                         : $urandom_range(0, 100);
            base           = $urandom;
            case ($urandom_range(0, 3))
                0:       spread = 0;
                1:       spread = sb.thresh_reg / 2;
                2:       spread = {sb.thresh_reg, 1'b0};
                default: spread = $urandom;
            endcase

            do begin
                if (!calm && $urandom_range(0, 39) == 0) begin
                    // Resize mid-frame once the stream has drained. Below row 0
                    // keep the width within the line entries already written.
                    wait_idle();
                    cap = (sb.row_pos != 0 && sb.filled < 12) ? sb.filled : 12;
                    if ($urandom_range(0, 1) == 1)
                        queue_reg(CFG_FRAME_WIDTH, CFG_DATA_W'($urandom_range(2, cap)));
                    else
                        queue_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'($urandom_range(0, 6)));
                    apply_regs();
                end
                case ($urandom_range(0, 19))
                    0: phase = $urandom;
                    1: begin
                        case ($urandom_range(0, 3))
                            0:       phase = 32'h8000_0000;
                            1:       phase = 32'h7FFF_FFFF;
                            2:       phase = 32'hFFFF_FFFF;
                            default: phase = 32'h0000_0000;
                        endcase
                    end
                    default: phase = base + $urandom_range(0, spread);
                endcase
                send_pixel(phase, $urandom_range(1, 100) <= mask_pct);
            end while (sb.col_pos != 0 || sb.row_pos != 0);
        end

        // Drain, allow for stray beats, then report.
        wait_idle();
        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("phase_unwrap_error_map_core verification clean");
        end else begin
            $display("phase_unwrap_error_map_core verification failed");
        end
        $finish;
    end

endmodule
